/* rtl/core/keyed_slot_table_top_assert.svh */
// Assertion helpers for the keyed slot table checker.
// Every property is clocked on i_clk and held off while i_rst_n is low.
`ifndef KEYED_SLOT_TABLE_TOP_ASSERT_SVH
`define KEYED_SLOT_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define KST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/kst_pkg.sv */
`timescale 1ns / 1ps
package kst_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KIND_W   = 3;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 3'd0,
        KIND_FIND   = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_READ   = 3'd3,
        KIND_CLEAR  = 3'd4
    } t_kind;

    // Input beat
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic [SLOT_W-1:0] index;
    } t_in;

    // Result beat
    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key_out;
        logic [PAY_W-1:0]  payload_out;
        logic [CNT_W-1:0]  slot_count;
    } t_out;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_RESOLVE,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic fetch;
        logic commit;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_is_scan;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/core/kst_datapath.sv */
`timescale 1ns / 1ps
module kst_datapath #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kst_pkg::t_in     i_in,
    input  kst_pkg::t_dp_cmd i_cmd,
    input  logic             i_out_ready,
    output kst_pkg::t_dp_sts o_sts,
    output logic             o_out_valid,
    output kst_pkg::t_out    o_out
);
    import kst_pkg::*;

    // stored payload width; the input field carries at most PAY_W bits
    localparam int PW = (PAYLOAD_BITS > PAY_W) ? PAY_W : PAYLOAD_BITS;

    // entry storage
    logic [KEY_W-1:0] mem_key [CAPACITY];
    logic [PW-1:0]    mem_pay [CAPACITY];

    // latched operation
    logic [KIND_W-1:0] r_kind;
    logic [KEY_W-1:0]  r_key;
    logic [PW-1:0]     r_pay;
    logic [SLOT_W-1:0] r_idx;

    // allocation and scan state
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_ptr;
    logic              r_rd_vld;
    logic [SLOT_W-1:0] r_rd_addr;
    logic [KEY_W-1:0]  r_rd_key;
    logic [PW-1:0]     r_rd_pay;

    // result holding and output registers
    t_out r_res, n_res;
    t_out r_out;
    logic r_out_valid;

    logic [KEY_W-1:0]  target;
    logic              hit;
    logic              scan_more;
    logic              idx_in;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [KEY_W-1:0]  wkey;
    logic [PW-1:0]     wpay;

    // scan compare: add looks for a free slot, find/remove for the key
    assign target    = (r_kind == KIND_ADD) ? '0 : r_key;
    assign hit       = r_rd_vld && (r_rd_key == target);
    assign scan_more = (r_ptr < r_count);
    assign idx_in    = (CNT_W'(r_idx) < r_count);

    assign rd_addr = i_cmd.fetch ? r_idx : r_ptr[SLOT_W-1:0];
    assign rd_en   = i_cmd.fetch || (i_cmd.scan && scan_more);

    // status
    always_comb begin
        o_sts.in_is_scan = (i_in.kind == KIND_ADD) || (i_in.kind == KIND_FIND) ||
                           (i_in.kind == KIND_REMOVE);
        o_sts.scan_done  = hit || (!scan_more && !r_rd_vld);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // result and write-back decision
    always_comb begin
        we      = 1'b0;
        waddr   = r_rd_addr;
        wkey    = '0;
        wpay    = '0;
        n_count = r_count;
        n_res   = '0;
        unique case (r_kind)
            KIND_ADD: begin
                wkey = r_key;
                wpay = r_pay;
                if (hit) begin
                    we         = 1'b1;
                    n_res.ok   = 1'b1;
                    n_res.slot = r_rd_addr;
                end else if (r_count < CNT_W'(CAPACITY)) begin
                    we         = 1'b1;
                    waddr      = r_count[SLOT_W-1:0];
                    n_count    = r_count + 1'b1;
                    n_res.ok   = 1'b1;
                    n_res.slot = r_count[SLOT_W-1:0];
                end
            end
            KIND_FIND: begin
                if (hit) begin
                    n_res.ok          = 1'b1;
                    n_res.slot        = r_rd_addr;
                    n_res.key_out     = r_rd_key;
                    n_res.payload_out = PAY_W'(r_rd_pay);
                end
            end
            KIND_REMOVE: begin
                if (hit) begin
                    we         = 1'b1;
                    n_res.ok   = 1'b1;
                    n_res.slot = r_rd_addr;
                end
            end
            KIND_READ: begin
                n_res.slot = r_idx;
                if (idx_in) begin
                    n_res.ok          = 1'b1;
                    n_res.key_out     = r_rd_key;
                    n_res.payload_out = PAY_W'(r_rd_pay);
                end
            end
            KIND_CLEAR: begin
                n_res.slot = r_idx;
                waddr      = r_idx;
                if (idx_in) begin
                    we       = 1'b1;
                    n_res.ok = 1'b1;
                end
            end
            default: ;
        endcase
        n_res.slot_count = n_count;
    end

    // operation latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_in.kind;
            r_key  <= i_in.key;
            r_pay  <= i_in.payload[PW-1:0];
            r_idx  <= i_in.index;
        end
    end

    // count, scan pointer and read-valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count <= n_count;
            end
            if (i_cmd.load) begin
                r_ptr    <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= scan_more;
                if (scan_more) begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end else begin
                r_rd_vld <= 1'b0;
            end
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && we) begin
            mem_key[waddr] <= wkey;
            mem_pay[waddr] <= wpay;
        end
        if (rd_en) begin
            r_rd_key  <= mem_key[rd_addr];
            r_rd_pay  <= mem_pay[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    // result holding register and output stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res <= n_res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* rtl/core/kst_ctrl.sv */
`timescale 1ns / 1ps
module kst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  kst_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output kst_pkg::t_dp_cmd o_cmd
);
    import kst_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.in_is_scan ? S_SCAN : S_FETCH;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_FETCH:   n_state = S_RESOLVE;
            S_RESOLVE: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.commit = i_sts.scan_done;
                o_cmd.scan   = !i_sts.scan_done;
            end
            S_FETCH:   o_cmd.fetch  = 1'b1;
            S_RESOLVE: o_cmd.commit = 1'b1;
            S_DONE:    o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

/* rtl/core/keyed_slot_table_top.sv */
`timescale 1ns / 1ps
// Keyed slot table: up to 64 slots of {key, payload}; a key of zero marks a free slot.
// Input channel (i_in_valid / o_in_ready / i_in) carries one operation per beat:
// add, find, remove, read or clear. Output channel (o_out_valid / i_out_ready /
// o_out) returns exactly one result beat per operation, in order.
// One operation is in flight at a time. Add, find and remove walk the allocated
// slots through the single read port of the entry memory, one slot per cycle,
// up to slot_count slots, and stop early at a match. Read, clear and unknown
// kinds read only the indexed slot. Each result is registered in a holding
// register and then moved into the output register that drives o_out_valid.
// A finished result sits in an output register; the next operation is accepted
// while it waits, and its own result is held until the output register frees,
// so a stalled receiver stops the block after at most one more operation.
// Reset (synchronous, active low) empties the table by zeroing the allocated
// count; entry contents are not cleared and no sweep is needed.
module keyed_slot_table_top #(
    parameter int PAYLOAD_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  kst_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output kst_pkg::t_out o_out
);
    import kst_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    kst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    kst_datapath #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

/* rtl/core/kst_checker.sv */
`timescale 1ns / 1ps
`include "keyed_slot_table_top_assert.svh"
module kst_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input kst_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input kst_pkg::t_out o_out
);
    import kst_pkg::*;

    // slot count of the last delivered result
    logic [CNT_W-1:0] r_last_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cnt <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_last_cnt <= o_out.slot_count;
        end
    end

    // a stalled result beat holds
    `KST_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "result beat changed while stalled")

    // one operation at a time: ready drops after an accept
    `KST_ASSERT_NEXT(a_in_busy, i_in_valid && o_in_ready, !o_in_ready, "input accepted while busy")

    // allocated count never shrinks
    `KST_ASSERT_NOW(a_cnt_mono, o_out_valid, o_out.slot_count >= r_last_cnt, "slot count shrank")

    // a successful operation names an allocated slot
    `KST_ASSERT_NOW(a_ok_slot, o_out_valid && o_out.ok, CNT_W'(o_out.slot) < o_out.slot_count, "ok slot beyond allocated count")

endmodule

bind keyed_slot_table_top kst_checker u_kst_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import kst_pkg::*;

    localparam int KIND_MAX     = (1 << KIND_W) - 1;
    localparam int IDLE_PCT     = 16;
    localparam int QUIET_LO     = 12000;
    localparam int QUIET_HI     = 20000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int POOL_MAX     = 96;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic drv_valid = 1'b0;
    t_in  drv_beat = '0;
    logic rcv_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out;

    // Shadow of the slot table
    logic [KEY_W-1:0] tbl_key[CAPACITY];
    logic [PAY_W-1:0] tbl_pay[CAPACITY];
    int tbl_used = 0;

    t_in  op_backlog[$];
    t_out want_results[$];
    logic [KEY_W-1:0] key_pool[$];

    int cycle = 0;
    int mismatches = 0;
    int ops_accepted = 0;
    int results_seen = 0;
    int adds_refused = 0;
    int lookup_hits = 0;
    int index_misses = 0;
    int peak_used = 0;

    keyed_slot_table_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (drv_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (drv_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (rcv_ready),
        .o_out       (o_out)
    );

    always #5 clk = ~clk;

    // Cycle count and run limit
    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT) begin
            $display("%0t ns: run limit reached, %0d results still pending",
                     $time, want_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Random idle cycle, except inside the quiet window
    function automatic bit idle_now();
        if (cycle >= QUIET_LO && cycle < QUIET_HI)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // Lowest allocated slot holding k, or tbl_used when there is none
    function automatic int lowest_slot_with(input logic [KEY_W-1:0] k);
        for (int i = 0; i < tbl_used; i++)
            if (tbl_key[i] == k)
                return i;
        return tbl_used;
    endfunction

    // Apply one operation to the shadow table and return its result
    function automatic t_out apply_op(input t_in op);
        t_out r;
        int s;
        r = '0;
        case (op.kind)
            KIND_ADD: begin
                s = lowest_slot_with('0);
                if (s >= tbl_used) begin
                    if (tbl_used < CAPACITY) begin
                        s = tbl_used;
                        tbl_used++;
                    end else begin
                        s = CAPACITY;
                    end
                end
                if (s < CAPACITY) begin
                    tbl_key[s] = op.key;
                    tbl_pay[s] = op.payload;
                    r.ok = 1'b1;
                    r.slot = SLOT_W'(s);
                end else begin
                    adds_refused++;
                end
            end
            KIND_FIND, KIND_REMOVE: begin
                s = lowest_slot_with(op.key);
                if (s < tbl_used) begin
                    r.ok = 1'b1;
                    r.slot = SLOT_W'(s);
                    if (op.kind == KIND_FIND) begin
                        r.key_out = tbl_key[s];
                        r.payload_out = tbl_pay[s];
                        lookup_hits++;
                    end else begin
                        tbl_key[s] = '0;
                        tbl_pay[s] = '0;
                    end
                end
            end
            KIND_READ, KIND_CLEAR: begin
                r.slot = op.index;
                if (op.index < tbl_used) begin
                    r.ok = 1'b1;
                    if (op.kind == KIND_READ) begin
                        r.key_out = tbl_key[op.index];
                        r.payload_out = tbl_pay[op.index];
                    end else begin
                        tbl_key[op.index] = '0;
                        tbl_pay[op.index] = '0;
                    end
                end else begin
                    index_misses++;
                end
            end
            default: ;
        endcase
        if (tbl_used > peak_used)
            peak_used = tbl_used;
        r.slot_count = CNT_W'(tbl_used);
        return r;
    endfunction

    task automatic push_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] payload, input logic [SLOT_W-1:0] index);
        t_in op;
        op.kind = kind;
        op.key = key;
        op.payload = payload;
        op.index = index;
        op_backlog.push_back(op);
    endtask

    // One random operation; keys for lookups mostly come from earlier adds
    task automatic push_random_op(input bit add_only);
        int pick;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0] key;
        logic [SLOT_W-1:0] index;
        pick = add_only ? 0 : $urandom_range(0, 99);
        if (pick < 35)
            kind = KIND_ADD;
        else if (pick < 55)
            kind = KIND_FIND;
        else if (pick < 70)
            kind = KIND_REMOVE;
        else if (pick < 82)
            kind = KIND_READ;
        else if (pick < 93)
            kind = KIND_CLEAR;
        else
            kind = KIND_W'($urandom_range(KIND_CLEAR + 1, KIND_MAX));

        pick = $urandom_range(0, 99);
        if (kind == KIND_ADD) begin
            key = (pick < 5) ? '0 : $urandom();
            key_pool.push_back(key);
            if (key_pool.size() > POOL_MAX)
                void'(key_pool.pop_front());
        end else if (pick < 60 && key_pool.size() != 0) begin
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else if (pick < 70) begin
            key = '0;
        end else begin
            key = $urandom();
        end

        if ($urandom_range(0, 1))
            index = SLOT_W'($urandom_range(0, 15));
        else
            index = SLOT_W'($urandom_range(0, CAPACITY - 1));
        push_op(kind, key, $urandom(), index);
    endtask

    task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Driver: present the next operation; predict when a beat is taken
    always @(posedge clk) begin : drv
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || o_in_ready) begin
            if (drv_valid) begin
                want_results.push_back(apply_op(drv_beat));
                ops_accepted++;
            end
            if (op_backlog.size() != 0 && !idle_now()) begin
                drv_valid <= 1'b1;
                drv_beat <= op_backlog.pop_front();
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge clk) begin : mon
        t_out want;
        if (!rst_n) begin
            rcv_ready <= 1'b0;
        end else begin
            if (o_out_valid && rcv_ready) begin
                if (want_results.size() == 0) begin
                    $display("%0t ns: result beat with nothing pending, expected none, got %p",
                             $time, o_out);
                    mismatches++;
                end else begin
                    want = want_results.pop_front();
                    check_field("ok", want.ok, o_out.ok);
                    check_field("slot", want.slot, o_out.slot);
                    check_field("key_out", want.key_out, o_out.key_out);
                    check_field("payload_out", want.payload_out, o_out.payload_out);
                    check_field("slot_count", want.slot_count, o_out.slot_count);
                    results_seen++;
                end
            end
            rcv_ready <= !idle_now();
        end
    end

    initial begin
        // Directed: empty table, unknown kinds, key zero, reuse, range edges
        push_op(KIND_FIND, 32'h5, '0, '0);
        push_op(KIND_REMOVE, '0, '0, '0);
        push_op(KIND_READ, '0, '0, '0);
        push_op(KIND_CLEAR, '0, '0, '1);
        for (int k = KIND_CLEAR + 1; k <= KIND_MAX; k++)
            push_op(KIND_W'(k), '1, '1, '1);
        push_op(KIND_ADD, '1, '1, '0);
        push_op(KIND_ADD, '0, 32'hA5A5_A5A5, '0);
        push_op(KIND_ADD, 32'h1, '0, '0);              // takes the free slot left by key zero
        push_op(KIND_ADD, 32'h8000_0000, 32'h5A5A_5A5A, '0);
        push_op(KIND_ADD, '0, 32'h0000_1234, '0);
        push_op(KIND_FIND, '0, '0, '0);                // key zero finds the free slot
        push_op(KIND_REMOVE, '0, '0, '0);
        push_op(KIND_FIND, '1, '0, '0);
        push_op(KIND_READ, '0, '0, SLOT_W'(2));
        push_op(KIND_READ, '0, '0, SLOT_W'(4));        // just past the allocated count
        push_op(KIND_READ, '0, '0, '1);
        push_op(KIND_CLEAR, '0, '0, '0);
        push_op(KIND_FIND, '1, '0, '0);
        push_op(KIND_REMOVE, 32'h8000_0000, '0, '0);
        push_op(KIND_REMOVE, 32'h8000_0000, '0, '0);
        push_op(KIND_ADD, 32'h7, 32'hFFFF_0000, '0);

        // Random: mixed traffic, a burst of adds to fill the table, mixed again
        for (int i = 0; i < 250; i++)
            push_random_op(1'b0);
        for (int i = 0; i < 90; i++)
            push_random_op(1'b1);
        for (int i = 0; i < 210; i++)
            push_random_op(1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (op_backlog.size() != 0 || drv_valid || want_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results of %0d operations; peak slot count %0d, %0d adds refused",
                 results_seen, ops_accepted, peak_used, adds_refused);
        $display("%0d finds hit a stored key, %0d read/clear beats fell outside the table",
                 lookup_hits, index_misses);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* keyed_slot_table_top.f */
+incdir+rtl/core
rtl/core/kst_pkg.sv
rtl/core/kst_datapath.sv
rtl/core/kst_ctrl.sv
rtl/core/keyed_slot_table_top.sv
rtl/core/kst_checker.sv
tb/testbench.sv
